/* rtl/rgbld_pkg.sv */
// ----------------------------------------------------------------------------
// rgbld_pkg: shared types and constants for the RGB LED blink/dim controller
// Sizes of the LED bank, channel coding, action codes and the request layout.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbld_pkg;

  // LED bank shape
  localparam int NumLeds  = 2;
  localparam int Channels = 3;
  localparam int PinW     = NumLeds * Channels;

  // Timer and counter widths
  localparam int CntW = 16;   // phase countdown and phase lengths
  localparam int PhW  = 9;    // blink phases left (twice an 8-bit count)
  localparam int LvlW = 7;    // saturated dim level

  // Dim PWM period in ticks and level ceiling
  localparam logic [CntW-1:0] DimPeriod = CntW'(100);
  localparam logic [LvlW-1:0] LevelMax  = LvlW'(100);

  // Action codes, also the per-LED activity state
  typedef enum logic [1:0] {
    ModeIdle   = 2'd0,
    ModeSteady = 2'd1,
    ModeBlink  = 2'd2,
    ModeDim    = 2'd3
  } mode_e;

  // Request kinds
  localparam logic FuncTick  = 1'b0;
  localparam logic FuncStart = 1'b1;

  // One request as held in the input register
  typedef struct packed {
    logic        func;
    logic        led;
    mode_e       mode;
    logic [2:0]  color;
    logic [15:0] on_time;
    logic [15:0] off_time;
    logic [7:0]  blink_count;
    logic [7:0]  dim_level;
  } req_t;

endpackage

`default_nettype wire

/* rtl/rgbld_led.sv */
// ----------------------------------------------------------------------------
// rgbld_led: state and next-state logic of one RGB LED
// Holds the action, phase timer and pin levels of one LED and applies a tick
// or a start request in one step, skipping zero-length phases at once.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbld_led import rgbld_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,    // apply the request this cycle
  input  logic                hit_i,     // start request addressed to this LED
  input  req_t                req_i,
  output logic [Channels-1:0] pins_n_o,
  output logic                busy_o
);

  // State registers
  mode_e               mode_q, mode_d;
  logic [Channels-1:0] color_q, color_d;
  logic [CntW-1:0]     on_q, on_d;
  logic [CntW-1:0]     off_q, off_d;
  logic [PhW-1:0]      phase_q, phase_d;
  logic [LvlW-1:0]     lvl_q, lvl_d;
  logic                high_q, high_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [Channels-1:0] pin_q, pin_d;

  // Phase-advance operands: fresh from the request or from the state
  mode_e               src_mode;
  logic [Channels-1:0] src_color;
  logic [CntW-1:0]     src_on, src_off;
  logic [PhW-1:0]      src_phase;
  logic [LvlW-1:0]     src_lvl;
  logic                src_high;

  // Phase-advance results
  mode_e               adv_mode;
  logic [PhW-1:0]      adv_phase;
  logic [CntW-1:0]     adv_cnt;
  logic [Channels-1:0] adv_pin;
  logic                adv_high;

  logic [LvlW-1:0]     sat_lvl;
  logic [Channels-1:0] lit_pins;
  logic [CntW-1:0]     dim_off_len;
  logic                active;

  assign active  = (mode_q == ModeBlink) || (mode_q == ModeDim);
  assign sat_lvl = (req_i.dim_level > 8'(LevelMax)) ? LevelMax : req_i.dim_level[LvlW-1:0];

  // Operand select
  always_comb begin
    if (hit_i) begin
      src_mode  = req_i.mode;
      src_color = req_i.color[Channels-1:0];
      src_on    = req_i.on_time;
      src_off   = req_i.off_time;
      src_phase = {req_i.blink_count, 1'b0};
      src_lvl   = sat_lvl;
      src_high  = 1'b0;
    end else begin
      src_mode  = mode_q;
      src_color = color_q;
      src_on    = on_q;
      src_off   = off_q;
      src_phase = phase_q;
      src_lvl   = lvl_q;
      src_high  = high_q;
    end
  end

  assign lit_pins    = ~src_color;
  assign dim_off_len = DimPeriod - CntW'(src_lvl);

  // Enter phases until one of nonzero length starts or the blink ends
  always_comb begin
    adv_mode  = src_mode;
    adv_phase = src_phase;
    adv_cnt   = '0;
    adv_pin   = '1;
    adv_high  = src_high;
    if (src_mode == ModeBlink) begin
      priority if (src_phase == '0) begin
        adv_mode = ModeIdle;
      end else if (src_phase[0]) begin
        // odd count: on phase is next
        priority if (src_on != '0) begin
          adv_pin   = lit_pins;
          adv_cnt   = src_on;
          adv_phase = src_phase - PhW'(1);
        end else if ((src_off != '0) && (src_phase != PhW'(1))) begin
          adv_cnt   = src_off;
          adv_phase = src_phase - PhW'(2);
        end else begin
          adv_mode  = ModeIdle;
          adv_phase = '0;
        end
      end else begin
        // even count: off phase is next
        priority if (src_off != '0) begin
          adv_cnt   = src_off;
          adv_phase = src_phase - PhW'(1);
        end else if (src_on != '0) begin
          adv_pin   = lit_pins;
          adv_cnt   = src_on;
          adv_phase = src_phase - PhW'(2);
        end else begin
          adv_mode  = ModeIdle;
          adv_phase = '0;
        end
      end
    end else if (src_mode == ModeDim) begin
      if (src_high) begin
        if (src_lvl != '0) begin
          adv_pin  = lit_pins;
          adv_cnt  = CntW'(src_lvl);
          adv_high = 1'b0;
        end else begin
          adv_cnt  = DimPeriod;
          adv_high = 1'b1;
        end
      end else begin
        if (dim_off_len != '0) begin
          adv_cnt  = dim_off_len;
          adv_high = 1'b1;
        end else begin
          adv_pin  = lit_pins;
          adv_cnt  = CntW'(src_lvl);
          adv_high = 1'b0;
        end
      end
    end
  end

  // Next state
  always_comb begin
    mode_d  = mode_q;
    color_d = color_q;
    on_d    = on_q;
    off_d   = off_q;
    phase_d = phase_q;
    lvl_d   = lvl_q;
    high_d  = high_q;
    cnt_d   = cnt_q;
    pin_d   = pin_q;
    if (step_i) begin
      if (hit_i) begin
        color_d = src_color;
        cnt_d   = '0;
        unique case (req_i.mode)
          ModeIdle: begin
            mode_d = ModeIdle;
            pin_d  = '1;
          end
          ModeSteady: begin
            mode_d = ModeSteady;
            pin_d  = lit_pins;
          end
          ModeBlink: begin
            on_d    = src_on;
            off_d   = src_off;
            mode_d  = adv_mode;
            phase_d = adv_phase;
            cnt_d   = adv_cnt;
            pin_d   = adv_pin;
          end
          ModeDim: begin
            lvl_d  = src_lvl;
            mode_d = adv_mode;
            high_d = adv_high;
            cnt_d  = adv_cnt;
            pin_d  = adv_pin;
          end
          default: begin
            mode_d = ModeIdle;
          end
        endcase
      end else if ((req_i.func == FuncTick) && active) begin
        if (cnt_q > CntW'(1)) begin
          cnt_d = cnt_q - CntW'(1);
        end else begin
          mode_d  = adv_mode;
          phase_d = adv_phase;
          cnt_d   = adv_cnt;
          pin_d   = adv_pin;
          high_d  = adv_high;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeIdle;
      color_q <= '0;
      on_q    <= '0;
      off_q   <= '0;
      phase_q <= '0;
      lvl_q   <= '0;
      high_q  <= 1'b0;
      cnt_q   <= '0;
      pin_q   <= '1;
    end else begin
      mode_q  <= mode_d;
      color_q <= color_d;
      on_q    <= on_d;
      off_q   <= off_d;
      phase_q <= phase_d;
      lvl_q   <= lvl_d;
      high_q  <= high_d;
      cnt_q   <= cnt_d;
      pin_q   <= pin_d;
    end
  end

  assign pins_n_o = pin_q;
  assign busy_o   = active;

endmodule

`default_nettype wire

/* rtl/rgb_led_blink_dim_controller_top.sv */
// ----------------------------------------------------------------------------
// rgb_led_blink_dim_controller_top: two-LED RGB blink and PWM dim controller
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | request   | in_valid_i / in_ready_o | func, led, mode, color,
//           |           |                         | on/off_time, blink_count,
//           |           |                         | dim_level
//   out     | result    | out_valid_o/out_ready_i | pins_n, busy_res
//
// One request per cycle sustained while out_ready_i stays high. An accepted
// request is held in the input register until the result register is free;
// then the LED state and the result are registered together from it.
// The result is the LED state itself; it holds while out_ready_i is low and
// the input register keeps one more request meanwhile.
// Reset leaves all LEDs idle and dark, with no request or result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_blink_dim_controller_top import rgbld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic              led_i,
  input  logic [1:0]        mode_i,
  input  logic [2:0]        color_i,
  input  logic [15:0]       on_time_i,
  input  logic [15:0]       off_time_i,
  input  logic [7:0]        blink_count_i,
  input  logic [7:0]        dim_level_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PinW-1:0]   pins_n_o,
  output logic [NumLeds-1:0] busy_res_o
);

  logic in_valid_q, in_valid_d;
  logic out_valid_q, out_valid_d;
  req_t req_q;
  logic step;
  logic accept;

  // Handshake control
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign accept      = in_valid_i && in_ready_o;
  assign in_valid_d  = accept || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input request register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.func        <= func_i;
      req_q.led         <= led_i;
      req_q.mode        <= mode_e'(mode_i);
      req_q.color       <= color_i;
      req_q.on_time     <= on_time_i;
      req_q.off_time    <= off_time_i;
      req_q.blink_count <= blink_count_i;
      req_q.dim_level   <= dim_level_i;
    end
  end

  // One state unit per LED
  for (genvar i = 0; i < NumLeds; i++) begin : g_led
    logic hit;
    assign hit = (req_q.func == FuncStart) && (int'(req_q.led) == i);

    rgbld_led u_led (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (step),
      .hit_i    (hit),
      .req_i    (req_q),
      .pins_n_o (pins_n_o[i*Channels +: Channels]),
      .busy_o   (busy_res_o[i])
    );
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/rgbld_checker.sv */
// ----------------------------------------------------------------------------
// rgbld_checker: port-level checks for the RGB LED controller
// Watches the top-level ports for result stability and request flow.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbld_checker import rgbld_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [PinW-1:0]    pins_n_o,
  input logic [NumLeds-1:0] busy_res_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pins_n_o) && $stable(busy_res_o))
    else $error("result changed while stalled");

  // With no result pending the input side never stalls
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // A result taken frees room for a new request in the same cycle
  a_ready_on_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input stalled while result drained");

  // Empty pipeline and no new request: no new result can appear
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !in_valid_i) ##1 !out_valid_o |=> !out_valid_o)
    else $error("result appeared without a request");

endmodule

bind rgb_led_blink_dim_controller_top rgbld_checker u_checker (.*);

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: RGB LED blink and PWM dim controller
// Sends tick and start requests, tracks both LEDs in a behavioral model and
// compares every pins_n/busy result against it, under varying back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import rgbld_pkg::*;

  localparam int QuietLimit = 1000;   // cycles without any handshake
  localparam int MaxShown   = 10;

  // Expected LED outputs after one request
  typedef struct packed {
    logic [PinW-1:0]    pins_n;
    logic [NumLeds-1:0] busy;
  } led_view_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic out_valid_o;
  logic out_ready_i;
  logic [PinW-1:0]    pins_n_o;
  logic [NumLeds-1:0] busy_res_o;
  req_t req_d;

  // Behavioral LED tracking state
  mode_e       led_act      [NumLeds];
  logic [2:0]  led_hue      [NumLeds];
  logic [15:0] lit_ticks    [NumLeds];
  logic [15:0] dark_ticks   [NumLeds];
  logic [8:0]  phases_to_go [NumLeds];
  logic [6:0]  duty         [NumLeds];
  logic        dim_lit_next [NumLeds];
  logic [15:0] ticks_left   [NumLeds];
  logic [2:0]  drive_n      [NumLeds];

  led_view_t led_view_q[$];
  int        fail_cnt;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;

  rgb_led_blink_dim_controller_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (req_d.func),
    .led_i         (req_d.led),
    .mode_i        (req_d.mode),
    .color_i       (req_d.color),
    .on_time_i     (req_d.on_time),
    .off_time_i    (req_d.off_time),
    .blink_count_i (req_d.blink_count),
    .dim_level_i   (req_d.dim_level),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pins_n_o      (pins_n_o),
    .busy_res_o    (busy_res_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Step an LED into its next phase; zero-length phases are passed through
  function automatic void enter_phase(input int i);
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      if (led_act[i] == ModeBlink) begin
        if (phases_to_go[i] == '0) begin
          led_act[i]    = ModeIdle;
          ticks_left[i] = '0;
          drive_n[i]    = '1;
          settled       = 1'b1;
        end else begin
          if (phases_to_go[i][0]) begin
            drive_n[i]    = ~led_hue[i];
            ticks_left[i] = lit_ticks[i];
          end else begin
            drive_n[i]    = '1;
            ticks_left[i] = dark_ticks[i];
          end
          phases_to_go[i] = phases_to_go[i] - 9'd1;
          settled         = (ticks_left[i] != '0);
        end
      end else if (led_act[i] == ModeDim) begin
        if (dim_lit_next[i]) begin
          drive_n[i]      = ~led_hue[i];
          dim_lit_next[i] = 1'b0;
          ticks_left[i]   = CntW'(duty[i]);
        end else begin
          drive_n[i]      = '1;
          dim_lit_next[i] = 1'b1;
          ticks_left[i]   = DimPeriod - CntW'(duty[i]);
        end
        settled = (ticks_left[i] != '0);
      end else begin
        settled = 1'b1;
      end
    end
  endfunction

  // Apply one request to the tracked LEDs and return the resulting outputs
  function automatic led_view_t apply_request(input req_t r);
    led_view_t view;
    int        n;
    if (r.func == FuncTick) begin
      for (int i = 0; i < NumLeds; i++) begin
        if (led_act[i] == ModeBlink || led_act[i] == ModeDim) begin
          if (ticks_left[i] > 16'd1) begin
            ticks_left[i] = ticks_left[i] - 16'd1;
          end else begin
            ticks_left[i] = '0;
            enter_phase(i);
          end
        end
      end
    end else begin
      n             = int'(r.led);
      led_hue[n]    = r.color;
      ticks_left[n] = '0;
      case (r.mode)
        ModeIdle: begin
          led_act[n] = ModeIdle;
          drive_n[n] = '1;
        end
        ModeSteady: begin
          led_act[n] = ModeSteady;
          drive_n[n] = ~r.color;
        end
        ModeBlink: begin
          led_act[n]      = ModeBlink;
          lit_ticks[n]    = r.on_time;
          dark_ticks[n]   = r.off_time;
          phases_to_go[n] = {r.blink_count, 1'b0};
          enter_phase(n);
        end
        default: begin
          led_act[n]      = ModeDim;
          duty[n]         = (r.dim_level > 8'(LevelMax)) ? LevelMax : r.dim_level[6:0];
          dim_lit_next[n] = 1'b0;
          enter_phase(n);
        end
      endcase
    end
    for (int i = 0; i < NumLeds; i++) begin
      view.pins_n[Channels*i +: Channels] = drive_n[i];
      view.busy[i] = (led_act[i] == ModeBlink || led_act[i] == ModeDim);
    end
    return view;
  endfunction

  // Request accept, result check, receiver stalls and watchdog
  always @(posedge clk_i) begin : check_results
    led_view_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        led_view_q.push_back(apply_request(req_d));
      end
      if (out_valid_o && out_ready_i) begin
        if (led_view_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxShown) $display("%0t: result with no request outstanding", $time);
        end else begin
          want = led_view_q.pop_front();
          if (pins_n_o !== want.pins_n || busy_res_o !== want.busy) begin
            fail_cnt++;
            if (fail_cnt <= MaxShown) begin
              $display("%0t: mismatch pins_n exp %b got %b, busy exp %b got %b", $time,
                       want.pins_n, pins_n_o, want.busy, busy_res_o);
            end
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);

    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one request, holding valid until it is taken
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_d      <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Tick with junk in every unused field
  function automatic req_t tick_req();
    req_t r;
    r.func        = FuncTick;
    r.led         = 1'($urandom);
    r.mode        = mode_e'($urandom_range(0, 3));
    r.color       = 3'($urandom);
    r.on_time     = 16'($urandom);
    r.off_time    = 16'($urandom);
    r.blink_count = 8'($urandom);
    r.dim_level   = 8'($urandom);
    return r;
  endfunction

  function automatic req_t start_req(input logic led, input mode_e mode,
                                     input logic [2:0] color, input logic [15:0] on_t,
                                     input logic [15:0] off_t, input logic [7:0] cnt,
                                     input logic [7:0] lvl);
    req_t r;
    r.func        = FuncStart;
    r.led         = led;
    r.mode        = mode;
    r.color       = color;
    r.on_time     = on_t;
    r.off_time    = off_t;
    r.blink_count = cnt;
    r.dim_level   = lvl;
    return r;
  endfunction

  // Mostly short phases so blinks run to the end, now and then a huge one
  function automatic logic [15:0] pick_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return 16'($urandom_range(0, 4));
    if (roll < 95) return 16'($urandom_range(0, 20));
    return 16'($urandom);
  endfunction

  // Each action, field extremes and the corner cases of phase handling
  task automatic test_commands_and_edges();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(tick_req());                                             // idle LEDs
    send_request(start_req(1'b0, ModeSteady, 3'd7, 16'd0, 16'd0, 8'd0, 8'd0));
    send_request(start_req(1'b1, ModeSteady, 3'd5, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    send_request(tick_req());                                             // steady holds
    send_request(start_req(1'b0, ModeIdle, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF));
    send_request(start_req(1'b0, ModeBlink, 3'd3, 16'd3, 16'd2, 8'd0, 8'd0)); // no cycles
    send_request(start_req(1'b1, ModeBlink, 3'd7, 16'd0, 16'd0, 8'd1, 8'd0)); // all zero
    send_request(start_req(1'b0, ModeBlink, 3'd1, 16'd1, 16'd0, 8'd2, 8'd0)); // off skipped
    send_request(tick_req());
    send_request(tick_req());
    send_request(tick_req());
    send_request(start_req(1'b1, ModeDim, 3'd6, 16'd0, 16'd0, 8'd0, 8'hFF));  // saturated
    send_request(start_req(1'b0, ModeDim, 3'd1, 16'd0, 16'd0, 8'd0, 8'd0));   // never lit
    send_request(start_req(1'b1, ModeDim, 3'd3, 16'd0, 16'd0, 8'd0, 8'd99));
    send_request(tick_req());
    send_request(start_req(1'b0, ModeBlink, 3'd7, 16'hFFFF, 16'hFFFF, 8'hFF, 8'd0));
    send_request(tick_req());
    send_request(start_req(1'b1, ModeBlink, 3'd2, 16'hFFFF, 16'd1, 8'h80, 8'd0)); // drops dim
    send_request(tick_req());
    send_request(tick_req());
    send_request(start_req(1'b0, ModeSteady, 3'd0, 16'd0, 16'd0, 8'd0, 8'd0)); // no channel
    send_request(start_req(1'b1, ModeIdle, 3'd0, 16'd0, 16'd0, 8'hFF, 8'd100));
    send_request(start_req(1'b1, ModeDim, 3'd4, 16'd0, 16'd0, 8'd0, 8'd100));  // off is zero
    send_request(tick_req());
  endtask

  // Full dim periods on both LEDs, through both edges of the PWM
  task automatic test_dim_period();
    send_idle_pct  = 26;
    recv_stall_pct = 26;
    send_request(start_req(1'b0, ModeDim, 3'd5, 16'd0, 16'd0, 8'd0, 8'd97));
    send_request(start_req(1'b1, ModeDim, 3'd2, 16'd0, 16'd0, 8'd0, 8'd2));
    repeat (105) send_request(tick_req());
  endtask

  // Commands mixed into a stream of ticks
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    req_t r;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) begin
      if ($urandom_range(0, 99) < 30) begin
        r = start_req(1'($urandom), mode_e'($urandom_range(0, 3)), 3'($urandom),
                      pick_len(), pick_len(), 8'd0, 8'd0);
        r.blink_count = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3))
                                                     : 8'($urandom_range(0, 255));
        r.dim_level   = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(92, 108));
      end else begin
        r = tick_req();
      end
      send_request(r);
    end
  endtask

  // Main sequence
  initial begin
    for (int i = 0; i < NumLeds; i++) begin
      led_act[i]      = ModeIdle;
      led_hue[i]      = '0;
      lit_ticks[i]    = '0;
      dark_ticks[i]   = '0;
      phases_to_go[i] = '0;
      duty[i]         = '0;
      dim_lit_next[i] = 1'b0;
      ticks_left[i]   = '0;
      drive_n[i]      = '1;
    end
    fail_cnt       = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    out_ready_i <= 1'b0;
    req_d       <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_commands_and_edges();
    test_dim_period();
    test_random_traffic(0, 0, 110);
    test_random_traffic(48, 0, 110);
    test_random_traffic(0, 48, 110);
    test_random_traffic(26, 26, 110);
    in_valid_i <= 1'b0;

    // Drain, then allow the pipeline to settle
    while (led_view_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    fail_cnt += led_view_q.size();

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/rgbld_pkg.sv
rtl/rgbld_led.sv
rtl/rgb_led_blink_dim_controller_top.sv
rtl/rgbld_checker.sv
test/testbench.sv
